/* rtl/hssc_pkg.sv */
// Shared types, constants and tables of the hall speed and sector calibrator.
package hssc_pkg;

  localparam int INDEX_COUNT  = 48;
  localparam int CAPTURE_BITS = 16;
  localparam int IDX_W        = $clog2(INDEX_COUNT);

  localparam int SPEED_W  = 24;
  localparam int CAL_W    = 25;
  localparam int FACTOR_W = 16;
  localparam int JUMP_W   = 12;
  localparam int PROD_W   = SPEED_W + FACTOR_W;
  localparam int NUM_W    = SPEED_W + 8;
  localparam int DEN_W    = CAPTURE_BITS + $clog2(INDEX_COUNT);
  localparam int CNT_W    = $clog2(NUM_W);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_FREQ  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_FACTOR = CFG_IDX_W'(1);

  localparam logic [SPEED_W-1:0]  TIMER_FREQ_RESET  = SPEED_W'(1000000);
  localparam logic [JUMP_W-1:0]   JUMP_FACTOR_RESET = JUMP_W'(384);
  localparam logic [SPEED_W-1:0]  SPEED_MAX         = '1;
  localparam logic [CAL_W-1:0]    CAL_MAX           = '1;
  localparam logic [FACTOR_W-1:0] UNITY_Q14         = FACTOR_W'(16384);
  localparam logic [2:0]          SECTOR_UNKNOWN    = 3'd6;
  localparam logic [2:0]          SECTOR_INDEX      = 3'd5;
  localparam logic [2:0]          HALL_ALL_LOW      = 3'b000;
  localparam logic [2:0]          HALL_ALL_HIGH     = 3'b111;

  localparam int ROM_DEPTH = 48;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);

  localparam logic [FACTOR_W-1:0] SPEED_FACTOR_ROM [ROM_DEPTH] = '{
    16'd5557,  16'd19397, 16'd25879, 16'd11906, 16'd17103, 16'd16189,
    16'd19495, 16'd11710, 16'd24745, 16'd11752, 16'd19484, 16'd15185,
    16'd17280, 16'd13143, 16'd26963, 16'd11158, 16'd16305, 16'd17626,
    16'd20305, 16'd10687, 16'd23600, 16'd15237, 16'd14420, 16'd16448,
    16'd20755, 16'd11457, 16'd22515, 16'd14880, 16'd14316, 16'd17713,
    16'd22364, 16'd9370,  16'd23518, 16'd17754, 16'd12781, 16'd15532,
    16'd25061, 16'd10063, 16'd21851, 16'd16066, 16'd13731, 16'd17311,
    16'd12511, 16'd33102, 16'd12242, 16'd9401,  16'd25833, 16'd35471
  };

  localparam logic [FACTOR_W-1:0] RPM_FACTOR_ROM [ROM_DEPTH] = '{
    16'd7869,  16'd23683, 16'd20005, 16'd12665, 16'd17428, 16'd16695,
    16'd16897, 16'd14200, 16'd19867, 16'd13155, 16'd18339, 16'd15421,
    16'd16640, 16'd15776, 16'd19666, 16'd11950, 16'd17547, 16'd17632,
    16'd16389, 16'd13225, 16'd20275, 16'd14077, 16'd15136, 16'd17198,
    16'd17133, 16'd13523, 16'd19340, 16'd14074, 16'd15496, 16'd17734,
    16'd16404, 16'd12018, 16'd21014, 16'd14639, 16'd13510, 16'd17318,
    16'd18268, 16'd11944, 16'd19445, 16'd14580, 16'd14868, 16'd17741,
    16'd16790, 16'd21989, 16'd11010, 16'd14565, 16'd25387, 16'd16101
  };

  typedef enum logic [1:0] {
    HALL_OK       = 2'd0,
    HALL_LOW_ERR  = 2'd1,
    HALL_HIGH_ERR = 2'd2
  } hall_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_JUMP,
    ST_UPDATE,
    ST_SECT,
    ST_CAL1,
    ST_CAL2,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MUL_JUMP,
    MUL_SPD,
    MUL_RPM
  } mul_sel_e;

  typedef struct packed {
    logic                    opcode;
    logic [CAPTURE_BITS-1:0] capture_count;
    logic [2:0]              hall_bits;
  } hssc_in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [CAL_W-1:0]   calibrated_speed;
    logic [CAL_W-1:0]   calibrated_rpm;
    logic [5:0]         mech_index;
    logic [2:0]         sector;
    logic [8:0]         angle_deg;
    logic [1:0]         hall_status;
  } hssc_out_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     speed_take;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     index_update;
    logic     sector_update;
    logic     cal_take;
    logic     emit;
  } hssc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } hssc_stat_t;

  function automatic logic [FACTOR_W-1:0] speed_factor(input logic [IDX_W-1:0] idx);
    if (int'(idx) < ROM_DEPTH) begin
      return SPEED_FACTOR_ROM[ROM_AW'(idx)];
    end
    return UNITY_Q14;
  endfunction

  function automatic logic [FACTOR_W-1:0] rpm_factor(input logic [IDX_W-1:0] idx);
    if (int'(idx) < ROM_DEPTH) begin
      return RPM_FACTOR_ROM[ROM_AW'(idx)];
    end
    return UNITY_Q14;
  endfunction

  function automatic logic [2:0] sector_decode(input logic [2:0] bits);
    logic [2:0] s;
    unique case (bits)
      3'b001:  s = 3'd2;
      3'b010:  s = 3'd0;
      3'b011:  s = 3'd1;
      3'b100:  s = 3'd4;
      3'b101:  s = 3'd3;
      3'b110:  s = 3'd5;
      default: s = SECTOR_UNKNOWN;
    endcase
    return s;
  endfunction

  function automatic logic [8:0] sector_angle(input logic [2:0] s);
    logic [8:0] a;
    unique case (s)
      3'd1:    a = 9'd60;
      3'd2:    a = 9'd120;
      3'd3:    a = 9'd180;
      3'd4:    a = 9'd240;
      3'd5:    a = 9'd300;
      default: a = 9'd0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/hssc_ctrl.sv */
// Sequencing state machine of the hall speed and sector calibrator.
module hssc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  output logic              in_ready_o,
  input  hssc_pkg::hssc_stat_t stat_i,
  output hssc_pkg::hssc_cmd_t  cmd_o
);
  import hssc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_opcode_i ? ST_SECT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = ST_JUMP;
        end
      end
      ST_JUMP:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_CAL1;
      ST_SECT:   state_d = ST_CAL1;
      ST_CAL1:   state_d = ST_CAL2;
      ST_CAL2:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_JUMP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_JUMP: begin
        // The old speed is multiplied by the jump ratio for the index test.
        cmd_o.speed_take = 1'b1;
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = MUL_JUMP;
      end
      ST_UPDATE: cmd_o.index_update  = 1'b1;
      ST_SECT:   cmd_o.sector_update = 1'b1;
      ST_CAL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SPD;
      end
      ST_CAL2: begin
        cmd_o.cal_take = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_RPM;
      end
      ST_EMIT:   cmd_o.emit = stat_i.out_free;
      default: begin
      end
    endcase
  end

endmodule

/* rtl/hssc_datapath.sv */
// Datapath: configuration, serial divider, shared multiplier, state and output register.
module hssc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [hssc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hssc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  hssc_pkg::hssc_in_t            in_i,
  input  hssc_pkg::hssc_cmd_t           cmd_i,
  output hssc_pkg::hssc_stat_t          stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hssc_pkg::hssc_out_t           out_o
);
  import hssc_pkg::*;

  logic [SPEED_W-1:0] timer_freq_q;
  logic [JUMP_W-1:0]  jump_factor_q;
  logic [SPEED_W-1:0] last_speed_q;
  logic [IDX_W-1:0]   index_q, index_d;
  logic [2:0]         sector_q;
  hall_status_e       status_q;
  logic               out_valid_q;

  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [DEN_W-1:0]   rem_q, rem_d;
  logic [DEN_W-1:0]   den_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               cap_zero_q;
  logic [2:0]         hall_q;
  logic [SPEED_W-1:0] new_speed_q, new_speed_d;
  logic [PROD_W-1:0]  prod_q;
  logic [FACTOR_W-1:0] mul_b;
  logic [CAL_W-1:0]   cal_spd_q;
  hssc_out_t          out_q;

  logic [DEN_W:0]     shifted;
  logic [DEN_W:0]     trial;
  logic               jump_hit;

  function automatic logic [CAL_W-1:0] cal_round(input logic [PROD_W-1:0] p);
    logic [PROD_W:0]    sum;
    logic [PROD_W-14:0] scaled;
    sum    = {1'b0, p} + (PROD_W+1)'(8192);
    scaled = sum[PROD_W:14];
    if (scaled > (PROD_W-13)'(CAL_MAX)) begin
      return CAL_MAX;
    end
    return scaled[CAL_W-1:0];
  endfunction

  // Restoring division, one quotient bit a cycle.
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    trial   = shifted - {1'b0, den_q};
    if (!trial[DEN_W]) begin
      rem_d = trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], 1'b0};
    end
  end

  always_comb begin
    if (cap_zero_q || (|quo_q[NUM_W-1:SPEED_W])) begin
      new_speed_d = SPEED_MAX;
    end else begin
      new_speed_d = quo_q[SPEED_W-1:0];
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SPD: mul_b = speed_factor(index_q);
      MUL_RPM: mul_b = rpm_factor(index_q);
      default: mul_b = FACTOR_W'(jump_factor_q);
    endcase
  end

  // The product register holds jump_factor times the old speed here.
  assign jump_hit = (sector_q == SECTOR_INDEX) &&
                    (prod_q < PROD_W'({new_speed_q, 8'b0}));

  always_comb begin
    if (jump_hit || (int'(index_q) >= INDEX_COUNT - 1)) begin
      index_d = '0;
    end else begin
      index_d = index_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_freq_q  <= TIMER_FREQ_RESET;
      jump_factor_q <= JUMP_FACTOR_RESET;
      last_speed_q  <= '0;
      index_q       <= IDX_W'(INDEX_COUNT - 1);
      sector_q      <= SECTOR_UNKNOWN;
      status_q      <= HALL_OK;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TIMER_FREQ:  timer_freq_q  <= cfg_data_i[SPEED_W-1:0];
          CFG_JUMP_FACTOR: jump_factor_q <= cfg_data_i[JUMP_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.index_update) begin
        index_q      <= index_d;
        last_speed_q <= new_speed_q;
      end
      if (cmd_i.sector_update) begin
        if (hall_q == HALL_ALL_LOW) begin
          status_q <= HALL_LOW_ERR;
        end else if (hall_q == HALL_ALL_HIGH) begin
          status_q <= HALL_HIGH_ERR;
        end else begin
          sector_q <= sector_decode(hall_q);
          status_q <= HALL_OK;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q      <= {timer_freq_q, 8'b0};
      rem_q      <= '0;
      den_q      <= DEN_W'(in_i.capture_count) * DEN_W'(INDEX_COUNT);
      cap_zero_q <= (in_i.capture_count == '0);
      cnt_q      <= '0;
      hall_q     <= in_i.hall_bits;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.speed_take) begin
      new_speed_q <= new_speed_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(last_speed_q) * PROD_W'(mul_b);
    end
    if (cmd_i.cal_take) begin
      cal_spd_q <= cal_round(prod_q);
    end
    if (cmd_i.emit) begin
      out_q.speed            <= last_speed_q;
      out_q.calibrated_speed <= cal_spd_q;
      out_q.calibrated_rpm   <= cal_round(prod_q);
      out_q.mech_index       <= 6'(index_q);
      out_q.sector           <= sector_q;
      out_q.angle_deg        <= sector_angle(sector_q);
      out_q.hall_status      <= status_q;
    end
  end

  assign stat_o.div_last = (cnt_q == CNT_W'(NUM_W - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_o           = out_q;

endmodule

/* rtl/hall_speed_sector_calibrator_unit.sv */
// Top level of the hall speed and sector calibrator.
//
// One request on the input channel is one hall event: opcode 0 carries a
// capture count and yields a new Q16.8 speed, opcode 1 carries the three
// hall levels and updates the electrical sector and status. Every request
// gives exactly one result on the output channel, holding the speed, both
// calibrated speeds, the mechanical index, the sector, its angle and status.
// A capture goes from acceptance to the result through the bit-serial
// divider, then the jump test, the index update and two passes through
// the single shared multiplier. A sector change goes through the sector
// update and the two multiplier passes. One request is in work at a time;
// the next may be accepted while the previous result still waits in the
// output register.
// If the receiver stalls, the finished result is held until the output
// register is free, and no further request is accepted until then.
// The configuration channel is always ready; writes are meant for idle time.
// Reset restores timer_freq and jump_factor, clears the speed, sets the
// index to its last value and the sector to unknown, with no result pending.
module hall_speed_sector_calibrator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  hssc_pkg::hssc_in_t              in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output hssc_pkg::hssc_out_t             out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hssc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hssc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import hssc_pkg::*;

  hssc_cmd_t  cmd;
  hssc_stat_t stat;

  assign cfg_ready_o = 1'b1;

  hssc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hssc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // Once a request is taken the block stays busy until its result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while the previous one was still in work");

  // A result is never loaded over one that has not yet been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten while occupied");

  // The index stays inside one revolution and the angle follows the sector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_o.mech_index) < INDEX_COUNT) &&
                    (out_o.angle_deg == sector_angle(out_o.sector)))
    else $error("result index or angle out of range");
`endif

endmodule

/* verif/tb.sv */
// Self-checking testbench for the hall speed and sector calibrator unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hssc_pkg::*;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_SECTOR  = 1'b1;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   SETTLE_CYCLES = 40;

  // Q2.14 calibration tables, indexed by the mechanical position.
  localparam logic [15:0] SPEED_CAL [48] = '{
    16'd5557,  16'd19397, 16'd25879, 16'd11906, 16'd17103, 16'd16189,
    16'd19495, 16'd11710, 16'd24745, 16'd11752, 16'd19484, 16'd15185,
    16'd17280, 16'd13143, 16'd26963, 16'd11158, 16'd16305, 16'd17626,
    16'd20305, 16'd10687, 16'd23600, 16'd15237, 16'd14420, 16'd16448,
    16'd20755, 16'd11457, 16'd22515, 16'd14880, 16'd14316, 16'd17713,
    16'd22364, 16'd9370,  16'd23518, 16'd17754, 16'd12781, 16'd15532,
    16'd25061, 16'd10063, 16'd21851, 16'd16066, 16'd13731, 16'd17311,
    16'd12511, 16'd33102, 16'd12242, 16'd9401,  16'd25833, 16'd35471
  };
  localparam logic [15:0] RPM_CAL [48] = '{
    16'd7869,  16'd23683, 16'd20005, 16'd12665, 16'd17428, 16'd16695,
    16'd16897, 16'd14200, 16'd19867, 16'd13155, 16'd18339, 16'd15421,
    16'd16640, 16'd15776, 16'd19666, 16'd11950, 16'd17547, 16'd17632,
    16'd16389, 16'd13225, 16'd20275, 16'd14077, 16'd15136, 16'd17198,
    16'd17133, 16'd13523, 16'd19340, 16'd14074, 16'd15496, 16'd17734,
    16'd16404, 16'd12018, 16'd21014, 16'd14639, 16'd13510, 16'd17318,
    16'd18268, 16'd11944, 16'd19445, 16'd14580, 16'd14868, 16'd17741,
    16'd16790, 16'd21989, 16'd11010, 16'd14565, 16'd25387, 16'd16101
  };
  localparam logic [2:0] SECTOR_FOR_HALL [8] = '{
    SECTOR_UNKNOWN, 3'd2, 3'd0, 3'd1, 3'd4, 3'd3, 3'd5, SECTOR_UNKNOWN
  };
  localparam logic [2:0] HALL_FOR_SECTOR [6] = '{
    3'b010, 3'b011, 3'b001, 3'b101, 3'b100, 3'b110
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  hssc_in_t  in_event = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  hssc_out_t out_report;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMER_FREQ;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted state of the block.
  logic [23:0]  tach_freq   = 24'd1000000;
  logic [11:0]  jump_ratio  = 12'd384;
  logic [23:0]  held_speed  = '0;
  logic [5:0]   mech_idx    = 6'(INDEX_COUNT - 1);
  logic [2:0]   elec_sector = SECTOR_UNKNOWN;
  hall_status_e hall_state  = HALL_OK;

  hssc_out_t pending_reports [$];

  int send_gap_pct   = 13;
  int recv_stall_pct = 52;
  int mismatch_count = 0;
  int events_sent    = 0;
  int captures_sent  = 0;
  int reports_checked = 0;
  int settings_used  = 0;
  int cycle_count    = 0;

  hall_speed_sector_calibrator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_event),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_report),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1ns clk_i = 1'b1;
    #1ns clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               pending_reports.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [24:0] calibrate(input logic [23:0] speed,
                                            input logic [15:0] factor);
    logic [63:0] scaled;
    scaled = (64'(speed) * 64'(factor) + 64'd8192) >> 14;
    return (scaled > 64'(CAL_MAX)) ? CAL_MAX : scaled[24:0];
  endfunction

  task automatic predict_hall_report(input hssc_in_t ev);
    logic [63:0] quotient;
    logic [23:0] speed;
    hssc_out_t   rpt;
    if (ev.opcode == OP_CAPTURE) begin
      if (ev.capture_count == '0) begin
        speed = SPEED_MAX;
      end else begin
        quotient = {32'd0, tach_freq, 8'd0} / (64'(INDEX_COUNT) * 64'(ev.capture_count));
        speed = (quotient > 64'(SPEED_MAX)) ? SPEED_MAX : quotient[23:0];
      end
      // A sharp rise in speed while in the last sector marks the index position.
      if (elec_sector == SECTOR_INDEX &&
          64'(jump_ratio) * 64'(held_speed) < {32'd0, speed, 8'd0}) begin
        mech_idx = '0;
      end else if (mech_idx >= 6'(INDEX_COUNT - 1)) begin
        mech_idx = '0;
      end else begin
        mech_idx = mech_idx + 6'd1;
      end
      held_speed = speed;
    end else if (ev.hall_bits == HALL_ALL_LOW) begin
      hall_state = HALL_LOW_ERR;
    end else if (ev.hall_bits == HALL_ALL_HIGH) begin
      hall_state = HALL_HIGH_ERR;
    end else begin
      elec_sector = SECTOR_FOR_HALL[ev.hall_bits];
      hall_state = HALL_OK;
    end
    rpt.speed = held_speed;
    rpt.calibrated_speed = calibrate(held_speed, (mech_idx < 6'd48) ? SPEED_CAL[mech_idx]
                                                                     : UNITY_Q14);
    rpt.calibrated_rpm = calibrate(held_speed, (mech_idx < 6'd48) ? RPM_CAL[mech_idx]
                                                                   : UNITY_Q14);
    rpt.mech_index = mech_idx;
    rpt.sector = elec_sector;
    rpt.angle_deg = (elec_sector < SECTOR_UNKNOWN) ? 9'(60 * elec_sector) : 9'd0;
    rpt.hall_status = hall_state;
    pending_reports.push_back(rpt);
  endtask

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result side: random stalls, and each accepted report is checked in order.
  always @(posedge clk_i) begin
    hssc_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("report with no request outstanding: %p", out_report);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        compare_field("speed", want.speed, out_report.speed);
        compare_field("calibrated_speed", want.calibrated_speed, out_report.calibrated_speed);
        compare_field("calibrated_rpm", want.calibrated_rpm, out_report.calibrated_rpm);
        compare_field("mech_index", want.mech_index, out_report.mech_index);
        compare_field("sector", want.sector, out_report.sector);
        compare_field("angle_deg", want.angle_deg, out_report.angle_deg);
        compare_field("hall_status", want.hall_status, out_report.hall_status);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic hssc_in_t capture_event(input logic [15:0] count);
    hssc_in_t ev;
    ev.opcode = OP_CAPTURE;
    ev.capture_count = count;
    ev.hall_bits = 3'($urandom);
    return ev;
  endfunction

  function automatic hssc_in_t sector_event(input logic [2:0] bits);
    hssc_in_t ev;
    ev.opcode = OP_SECTOR;
    ev.capture_count = 16'($urandom);
    ev.hall_bits = bits;
    return ev;
  endfunction

  // Valid stays high from one request to the next unless a gap is drawn.
  task automatic send_hall_event(input hssc_in_t ev);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_event <= ev;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_hall_report(ev);
    events_sent++;
    if (ev.opcode == OP_CAPTURE) captures_sent++;
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_rates(input logic [23:0] freq, input logic [11:0] ratio,
                               input logic [11:0] pad);
    drain_reports();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TIMER_FREQ;
    cfg_data <= freq;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    tach_freq = freq;
    cfg_index <= CFG_JUMP_FACTOR;
    cfg_data <= {pad, ratio};
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    jump_ratio = ratio;
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic test_capture_extremes();
    send_hall_event(capture_event(16'h0000));
    send_hall_event(capture_event(16'h0001));
    send_hall_event(capture_event(16'hFFFF));
    send_hall_event(capture_event(16'hAAAA));
    send_hall_event(capture_event(16'h5555));
  endtask

  task automatic test_hall_patterns();
    // Invalid patterns first, while the sector is still unknown.
    send_hall_event(sector_event(HALL_ALL_LOW));
    send_hall_event(sector_event(HALL_ALL_HIGH));
    for (int s = 0; s < 6; s++) send_hall_event(sector_event(HALL_FOR_SECTOR[s]));
    // Now in the last sector; invalid patterns must keep it.
    send_hall_event(sector_event(HALL_ALL_LOW));
    send_hall_event(sector_event(HALL_ALL_HIGH));
  endtask

  task automatic test_index_jump();
    send_hall_event(capture_event(16'hFFFF));
    send_hall_event(capture_event(16'h0010));
    send_hall_event(capture_event(16'h0011));
  endtask

  task automatic test_speed_extremes();
    program_rates(24'hFFFFFF, 12'd4095, 12'd0);
    send_hall_event(capture_event(16'h0001));
    // The slowest timer gives a speed of zero, which can never count as a jump.
    program_rates(24'd1, 12'd0, 12'd0);
    send_hall_event(capture_event(16'hFFFF));
    send_hall_event(capture_event(16'h0005));
  endtask

  // One full turn outside the index sector, with saturated speed at the
  // positions whose speed factors exceed two, so the calibrated speed clips.
  task automatic test_full_revolution();
    logic [5:0] next_idx;
    send_hall_event(sector_event(HALL_FOR_SECTOR[0]));
    for (int i = 0; i < INDEX_COUNT; i++) begin
      next_idx = (mech_idx >= 6'(INDEX_COUNT - 1)) ? 6'd0 : mech_idx + 6'd1;
      if (next_idx == 6'd43 || next_idx == 6'd47) begin
        send_hall_event(capture_event(16'h0000));
      end else begin
        send_hall_event(capture_event(16'($urandom)));
      end
    end
  endtask

  task automatic test_random_traffic(input int count);
    int target;
    int pos;
    int dir;
    int steps;
    int base;
    int cap;
    hssc_in_t ev;
    target = events_sent + count;
    while (events_sent < target) begin
      if ($urandom_range(3) != 0) begin
        // Rotor turning steadily through the sectors, in either direction.
        pos = (elec_sector < SECTOR_UNKNOWN) ? int'(elec_sector) : $urandom_range(0, 5);
        dir = $urandom_range(1) ? 1 : 5;
        steps = $urandom_range(3, 14);
        base = $urandom_range(1, 65535) >> $urandom_range(0, 15);
        if (base == 0) base = 1;
        for (int k = 0; k < steps && events_sent < target; k++) begin
          pos = (pos + dir) % 6;
          send_hall_event(sector_event(HALL_FOR_SECTOR[pos]));
          cap = base - base / 16 + $urandom_range(0, base / 8);
          if (pos == 5 && $urandom_range(3) == 0) cap = cap / $urandom_range(2, 6);
          if ($urandom_range(19) == 0) cap = 0;
          if (cap > 65535) cap = 65535;
          send_hall_event(capture_event(16'(cap)));
        end
      end else begin
        ev.opcode = 1'($urandom);
        ev.capture_count = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 15))
                                                    : 16'($urandom);
        ev.hall_bits = 3'($urandom_range(0, 7));
        send_hall_event(ev);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_capture_extremes();
    test_hall_patterns();
    test_index_jump();
    test_speed_extremes();

    program_rates(24'd1000000, 12'd384, 12'($urandom));
    test_full_revolution();
    test_random_traffic(160);

    send_gap_pct = 52;
    recv_stall_pct = 13;
    program_rates(24'hFFFFFF, 12'd0, 12'($urandom));
    test_random_traffic(80);
    program_rates(24'($urandom_range(1, 24'hFFFFFF)), 12'd4095, 12'($urandom));
    test_random_traffic(80);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    program_rates(24'($urandom_range(1, 24'hFFFFFF)), 12'($urandom_range(0, 4095)),
                  12'($urandom));
    test_random_traffic(160);

    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d hall requests sent (%0d speed captures), %0d reports checked",
             events_sent, captures_sent, reports_checked);
    $display("%0d timer and jump settings used, %0d cycles", settings_used, cycle_count);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/hssc_pkg.sv
rtl/hssc_ctrl.sv
rtl/hssc_datapath.sv
rtl/hall_speed_sector_calibrator_unit.sv
verif/tb.sv
